FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker of the hasher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SFH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define SFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define SFH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication across reset");

`endif

FILE: src/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Types, constants and mixing functions of the SuperFastHash stream hasher.
// ----------------------------------------------------------------------------
package sfh_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned LEN_W   = 31;

    localparam logic [COUNT_W-1:0] CNT_NONE  = 3'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO   = 3'd2;
    localparam logic [COUNT_W-1:0] CNT_THREE = 3'd3;
    localparam logic [COUNT_W-1:0] CNT_FULL  = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0]  data_word;
        logic [COUNT_W-1:0] byte_count;
        logic               first_word;
        logic               last_word;
        logic [LEN_W-1:0]   msg_len;
        logic               empty_msg;
    } item_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    function automatic logic [WORD_W-1:0] sext8(input logic [7:0] b);
        return {{(WORD_W-8){b[7]}}, b};
    endfunction

    function automatic logic [WORD_W-1:0] mix_word(
        input logic [WORD_W-1:0]  h_in,
        input logic [WORD_W-1:0]  w,
        input logic [COUNT_W-1:0] count
    );
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] t;
        h  = h_in;
        lo = {16'h0000, w[15:0]};
        hi = {16'h0000, w[31:16]};
        t  = '0;
        unique case (count)
            CNT_FULL:
            begin
                h = h + lo;
                t = (hi << 11) ^ h;
                h = (h << 16) ^ t;
                h = h + (h >> 11);
            end
            CNT_THREE:
            begin
                h = h + lo;
                h = h ^ (h << 16);
                h = h ^ (sext8(w[23:16]) << 18);
                h = h + (h >> 11);
            end
            CNT_TWO:
            begin
                h = h + lo;
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            CNT_ONE:
            begin
                h = h + sext8(w[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] aval_a(input logic [WORD_W-1:0] h_in);
        logic [WORD_W-1:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] aval_b(input logic [WORD_W-1:0] h_in);
        logic [WORD_W-1:0] h;
        h = h_in ^ (h_in << 4);
        h = h + (h >> 17);
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] aval_c(input logic [WORD_W-1:0] h_in);
        logic [WORD_W-1:0] h;
        h = h_in ^ (h_in << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

FILE: src/sfh_front.sv
// ----------------------------------------------------------------------------
// sfh_front
// Accepts input beats, clamps the byte count and flags empty messages.
// ----------------------------------------------------------------------------
module sfh_front (
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sfh_pkg::WORD_W-1:0]  data_word,
    input  logic [sfh_pkg::COUNT_W-1:0] byte_count,
    input  logic                        first_word,
    input  logic                        last_word,
    input  logic [sfh_pkg::LEN_W-1:0]   msg_len,
    input  sfh_pkg::queue_status_t      q_status,
    output logic                        push,
    output sfh_pkg::item_t              item
);

    logic [sfh_pkg::COUNT_W-1:0] count_clamped;

    always_comb
    begin
        count_clamped = (byte_count > sfh_pkg::CNT_FULL) ? sfh_pkg::CNT_FULL : byte_count;
        item.data_word  = data_word;
        item.byte_count = count_clamped;
        item.first_word = first_word;
        item.last_word  = last_word;
        item.msg_len    = msg_len;
        item.empty_msg  = (count_clamped == sfh_pkg::CNT_NONE)
                        || (first_word && (msg_len == '0));
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

FILE: src/sfh_queue.sv
// ----------------------------------------------------------------------------
// sfh_queue
// Two-entry queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module sfh_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sfh_pkg::item_t         push_item,
    input  logic                   pop,
    output sfh_pkg::item_t         head_item,
    output sfh_pkg::queue_status_t q_status
);

    sfh_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item      = entry_reg[rd_ptr_reg];
    assign q_status.full  = count_reg[1];
    assign q_status.valid = (count_reg != 2'd0);

endmodule

FILE: src/sfh_back.sv
// ----------------------------------------------------------------------------
// sfh_back
// Mixing round on the running hash, three-stage avalanche and output register.
// ----------------------------------------------------------------------------
module sfh_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfh_pkg::item_t             head_item,
    input  sfh_pkg::queue_status_t     q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [sfh_pkg::WORD_W-1:0] hash_value
);

    logic                       adv;
    logic [sfh_pkg::WORD_W-1:0] seed;
    logic [sfh_pkg::WORD_W-1:0] mixed;

    logic [sfh_pkg::WORD_W-1:0] hash_reg;
    logic [sfh_pkg::WORD_W-1:0] hash_next;

    logic                       s1_valid_reg;
    logic                       s2_valid_reg;
    logic                       s3_valid_reg;
    logic                       out_valid_reg;
    logic                       s1_empty_reg;
    logic                       s2_empty_reg;
    logic                       s3_empty_reg;
    logic [sfh_pkg::WORD_W-1:0] s1_hash_reg;
    logic [sfh_pkg::WORD_W-1:0] s2_hash_reg;
    logic [sfh_pkg::WORD_W-1:0] s3_hash_reg;
    logic [sfh_pkg::WORD_W-1:0] out_hash_reg;

    assign adv = !(out_valid_reg && out_stall);
    assign pop = q_status.valid && adv;

    always_comb
    begin
        seed      = head_item.first_word ? {1'b0, head_item.msg_len} : hash_reg;
        mixed     = sfh_pkg::mix_word(seed, head_item.data_word, head_item.byte_count);
        hash_next = hash_reg;
        if (pop)
        begin
            hash_next = head_item.last_word ? '0 : mixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            if (adv)
            begin
                s1_valid_reg  <= pop && head_item.last_word;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_hash_reg  <= mixed;
            s1_empty_reg <= head_item.empty_msg;
            s2_hash_reg  <= sfh_pkg::aval_a(s1_hash_reg);
            s2_empty_reg <= s1_empty_reg;
            s3_hash_reg  <= sfh_pkg::aval_b(s2_hash_reg);
            s3_empty_reg <= s2_empty_reg;
            out_hash_reg <= s3_empty_reg ? '0 : sfh_pkg::aval_c(s3_hash_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

endmodule

FILE: src/superfasthash_stream_hasher.sv
// ----------------------------------------------------------------------------
// superfasthash_stream_hasher
// 32-bit SuperFastHash over messages streamed as little-endian 4-byte words.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low and returns one hash per
// message, after the last word has passed the queue entry, the s1, s2 and
// s3 registers and the output register. The running hash is updated by a
// combinational mixing round, so a word may follow in the very next cycle;
// the avalanche runs in a three-stage pipeline behind it, and a two-entry
// queue separates input acceptance from the mixing loop so a stalled output
// holds the input off only once the queue is full.
module superfasthash_stream_hasher (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sfh_pkg::WORD_W-1:0]  data_word,
    input  logic [sfh_pkg::COUNT_W-1:0] byte_count,
    input  logic                        first_word,
    input  logic                        last_word,
    input  logic [sfh_pkg::LEN_W-1:0]   msg_len,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sfh_pkg::WORD_W-1:0]  hash_value
);

    sfh_pkg::item_t         front_item;
    sfh_pkg::item_t         head_item;
    sfh_pkg::queue_status_t q_status;
    logic                   push;
    logic                   pop;

    sfh_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .byte_count (byte_count),
        .first_word (first_word),
        .last_word  (last_word),
        .msg_len    (msg_len),
        .q_status   (q_status),
        .push       (push),
        .item       (front_item)
    );

    sfh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    sfh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

endmodule

FILE: src/sfh_checker.sv
// ----------------------------------------------------------------------------
// sfh_checker
// Port-level checks of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfh_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [sfh_pkg::WORD_W-1:0] hash_value
);

    `SFH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `SFH_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(hash_value))
    `SFH_ASSERT_NEXT_ALWAYS(a_rst_no_out, clk, !rst_n, !out_valid)
    `SFH_ASSERT_NEXT_ALWAYS(a_rst_ready, clk, !rst_n, !in_stall)
    // Input only backs up when the output side is stalled.
    `SFH_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall && in_valid, $past(out_stall))

endmodule

bind superfasthash_stream_hasher sfh_checker u_sfh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
);
